>>> hdl/ipa_pkg.sv
// Package with shared types, constants and the digit-to-character function.
`timescale 1ns / 1ps

package ipa_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int BCD_DIGITS = 10;
    localparam int VALUE_BITS = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ALPHA = 8'h37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CONV,
        ST_SKIP,
        ST_PAD_L,
        ST_SIGN,
        ST_DIGIT,
        ST_PAD_R
    } state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] char_code;
        logic       last;
    } emit_t;

    function automatic logic [7:0] digit_char(input logic [3:0] digit);
        logic [7:0] result;
        if (digit < 4'd10) begin
            result = CHAR_ZERO + {4'h0, digit};
        end else begin
            result = CHAR_ALPHA + {4'h0, digit};
        end
        return result;
    endfunction

endpackage

>>> hdl/ipa_dabble.sv
// Bit-serial binary to BCD converter using the shift-and-add-three method.
`timescale 1ns / 1ps

module ipa_dabble (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [ipa_pkg::VALUE_BITS-1:0]         bin,
    output logic                                   done,
    output logic [4*ipa_pkg::BCD_DIGITS-1:0]       bcd
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [4:0]                           count_reg, count_next;
    logic [ipa_pkg::VALUE_BITS-1:0]       bin_reg, bin_next;
    logic [4*ipa_pkg::BCD_DIGITS-1:0]     bcd_reg, bcd_next;
    logic [4*ipa_pkg::BCD_DIGITS-1:0]     bcd_adj;

    always_comb begin
        for (int i = 0; i < ipa_pkg::BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] > 4'd4) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            bin_next   = bin;
            bcd_next   = '0;
        end else if (busy_reg) begin
            bcd_next   = {bcd_adj[4*ipa_pkg::BCD_DIGITS-2:0], bin_reg[ipa_pkg::VALUE_BITS-1]};
            bin_next   = {bin_reg[ipa_pkg::VALUE_BITS-2:0], 1'b0};
            count_next = count_reg + 5'd1;
            if (count_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> hdl/ipa_out.sv
// Output register stage for the character channel.
`timescale 1ns / 1ps

module ipa_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  ipa_pkg::emit_t emit,
    output logic           can_take,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_char,
    output logic           m_last_char
);

    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;

    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (can_take) begin
            valid_next = emit.push;
            char_next  = emit.char_code;
            last_next  = emit.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_char  = char_reg;
    assign m_last_char = last_reg;

endmodule

>>> hdl/integer_to_padded_ascii.sv
// Top level: formats a 32-bit value as padded decimal or hexadecimal ASCII text.
// In decimal the value first passes through the 32-step BCD shift loop; leading zero
// digits are then skipped, keeping at least one (0 to 9, at least 2 in hexadecimal).
// Throughput: one character per cycle after the first while m_ready does not stall the
// output; the next value is accepted once the last character has been handed to the
// output register.
// Reset: aresetn is synchronous and active low; it returns the sequencer to idle and empties
// the output register.
`timescale 1ns / 1ps

module integer_to_padded_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic        s_hex_mode,
    input  logic [6:0]  s_field_width,
    input  logic        s_left_justify,
    input  logic        s_zero_pad,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_char
);

    localparam int DigBits = 4 * ipa_pkg::BCD_DIGITS;

    ipa_pkg::state_t state_reg, state_next;

    logic [31:0]        mag_reg, mag_next;
    logic               hex_reg, hex_next;
    logic               neg_reg, neg_next;
    logic               left_reg, left_next;
    logic [7:0]         pad_reg, pad_next;
    logic [6:0]         width_reg, width_next;
    logic [DigBits-1:0] dig_reg, dig_next;
    logic [3:0]         ndig_reg, ndig_next;
    logic [6:0]         cnt_reg, cnt_next;

    logic               conv_start;
    logic               conv_done;
    logic [DigBits-1:0] conv_bcd;
    logic               can_take;
    ipa_pkg::emit_t     emit;

    logic               top_zero;
    logic [6:0]         text_len;
    logic [6:0]         pad_count;

    assign top_zero  = (dig_reg[DigBits-1 -: 4] == 4'h0);
    assign text_len  = {3'b000, ndig_reg} + {6'b000000, neg_reg};
    assign pad_count = (width_reg > text_len) ? (width_reg - text_len) : 7'd0;
    assign s_ready   = (state_reg == ipa_pkg::ST_IDLE);

    ipa_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .bin     (mag_reg),
        .done    (conv_done),
        .bcd     (conv_bcd)
    );

    ipa_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .emit        (emit),
        .can_take    (can_take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ipa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ipa_pkg::ST_LOAD;
                end
            end
            ipa_pkg::ST_LOAD: begin
                state_next = hex_reg ? ipa_pkg::ST_SKIP : ipa_pkg::ST_CONV;
            end
            ipa_pkg::ST_CONV: begin
                if (conv_done) begin
                    state_next = ipa_pkg::ST_SKIP;
                end
            end
            ipa_pkg::ST_SKIP: begin
                if (!(top_zero && ndig_reg > 4'd1)) begin
                    if (!left_reg && pad_count != 7'd0) begin
                        state_next = ipa_pkg::ST_PAD_L;
                    end else if (neg_reg) begin
                        state_next = ipa_pkg::ST_SIGN;
                    end else begin
                        state_next = ipa_pkg::ST_DIGIT;
                    end
                end
            end
            ipa_pkg::ST_PAD_L: begin
                if (can_take && cnt_reg == 7'd1) begin
                    state_next = neg_reg ? ipa_pkg::ST_SIGN : ipa_pkg::ST_DIGIT;
                end
            end
            ipa_pkg::ST_SIGN: begin
                if (can_take) begin
                    state_next = ipa_pkg::ST_DIGIT;
                end
            end
            ipa_pkg::ST_DIGIT: begin
                if (can_take && ndig_reg == 4'd1) begin
                    if (left_reg && cnt_reg != 7'd0) begin
                        state_next = ipa_pkg::ST_PAD_R;
                    end else begin
                        state_next = ipa_pkg::ST_IDLE;
                    end
                end
            end
            ipa_pkg::ST_PAD_R: begin
                if (can_take && cnt_reg == 7'd1) begin
                    state_next = ipa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ipa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mag_next       = mag_reg;
        hex_next       = hex_reg;
        neg_next       = neg_reg;
        left_next      = left_reg;
        pad_next       = pad_reg;
        width_next     = width_reg;
        dig_next       = dig_reg;
        ndig_next      = ndig_reg;
        cnt_next       = cnt_reg;
        conv_start     = 1'b0;
        emit.push      = 1'b0;
        emit.char_code = pad_reg;
        emit.last      = 1'b0;
        unique case (state_reg)
            ipa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    hex_next  = s_hex_mode;
                    neg_next  = !s_hex_mode && s_value[31];
                    mag_next  = (!s_hex_mode && s_value[31]) ? (32'd0 - s_value) : s_value;
                    left_next = s_left_justify;
                    pad_next  = s_zero_pad ? ipa_pkg::CHAR_ZERO : ipa_pkg::CHAR_SPACE;
                    width_next = (s_field_width > 7'(ipa_pkg::MAX_WIDTH))
                                 ? 7'(ipa_pkg::MAX_WIDTH) : s_field_width;
                end
            end
            ipa_pkg::ST_LOAD: begin
                ndig_next = 4'(ipa_pkg::BCD_DIGITS);
                if (hex_reg) begin
                    dig_next = {{(DigBits-32){1'b0}}, mag_reg};
                end else begin
                    conv_start = 1'b1;
                end
            end
            ipa_pkg::ST_CONV: begin
                if (conv_done) begin
                    dig_next = conv_bcd;
                end
            end
            ipa_pkg::ST_SKIP: begin
                if (top_zero && ndig_reg > 4'd1) begin
                    dig_next  = {dig_reg[DigBits-5:0], 4'h0};
                    ndig_next = ndig_reg - 4'd1;
                end else begin
                    cnt_next = pad_count;
                end
            end
            ipa_pkg::ST_PAD_L: begin
                emit.push = 1'b1;
                if (can_take) begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            ipa_pkg::ST_SIGN: begin
                emit.push      = 1'b1;
                emit.char_code = ipa_pkg::CHAR_MINUS;
            end
            ipa_pkg::ST_DIGIT: begin
                emit.push      = 1'b1;
                emit.char_code = ipa_pkg::digit_char(dig_reg[DigBits-1 -: 4]);
                emit.last      = (ndig_reg == 4'd1) && !(left_reg && cnt_reg != 7'd0);
                if (can_take) begin
                    dig_next  = {dig_reg[DigBits-5:0], 4'h0};
                    ndig_next = ndig_reg - 4'd1;
                end
            end
            ipa_pkg::ST_PAD_R: begin
                emit.push = 1'b1;
                emit.last = (cnt_reg == 7'd1);
                if (can_take) begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            default: begin
                emit.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg   <= mag_next;
        hex_reg   <= hex_next;
        neg_reg   <= neg_next;
        left_reg  <= left_next;
        pad_reg   <= pad_next;
        width_reg <= width_next;
        dig_reg   <= dig_next;
        ndig_reg  <= ndig_next;
        cnt_reg   <= cnt_next;
    end

endmodule
